[sv/mav_pkg.sv]
// ----------------------------------------------------------------------------
// mav_pkg
// Shared constants and types for the moving average window block.
// ----------------------------------------------------------------------------
package mav_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int CFG_W        = 7;
  localparam int MIN_WINDOW   = 2;
  localparam int RESET_WINDOW = 8;

  // Access command to the sample ring: one access per cycle.
  typedef struct packed {
    logic rd;
    logic wr;
  } ring_cmd_t;

endpackage

[sv/mav_ring.sv]
// ----------------------------------------------------------------------------
// mav_ring
// Single-port sample store with registered read data.
// ----------------------------------------------------------------------------
module mav_ring #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                                clk,
  input  mav_pkg::ring_cmd_t                  cmd,
  input  logic [ADDR_W-1:0]                   addr,
  input  logic signed [mav_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [mav_pkg::SAMPLE_W-1:0] rd_data
);
  import mav_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[addr];
    end
  end

endmodule

[sv/mav_div.sv]
// ----------------------------------------------------------------------------
// mav_div
// Radix-2 restoring divider: signed sum by unsigned length, quotient
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mav_div #(
  parameter int SUM_W = 38,
  parameter int LEN_W = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [SUM_W-1:0]             dividend,
  input  logic [LEN_W-1:0]                    divisor,
  output logic                                done,
  output logic signed [mav_pkg::SAMPLE_W-1:0] quotient
);
  import mav_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] acc;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             running;
  logic             neg;

  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   diff;
  logic             ge;
  logic [SAMPLE_W-1:0] q_low;

  always_comb begin
    rem_sh = {rem, acc[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
    q_low  = acc[SAMPLE_W-1:0];
    quotient = neg ? $signed(-q_low) : $signed(q_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc     <= dividend[SUM_W-1] ? -dividend : dividend;
        neg     <= dividend[SUM_W-1];
        dvs     <= divisor;
        rem     <= '0;
        count   <= CNT_W'(SUM_W - 1);
        running <= 1'b1;
      end else if (running) begin
        acc <= {acc[SUM_W-2:0], ge};
        rem <= ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

endmodule

[sv/moving_average_window.sv]
// ----------------------------------------------------------------------------
// moving_average_window
// Boxcar average over the most recent window_length samples.
//
//   channel        signals                               direction
//   sample         sample_valid, sample_stall, sample    in
//   average        average_valid, average_stall, average out
//   window_length  window_length_wr, window_length       in (config)
//
// One sample at a time: a new sample is taken only once the bit-serial
// divider of the running sum has delivered the previous average.
// The sample ring lives in a single-port RAM: read the old entry, then
// write the new one; unwritten entries are masked by a wrap flag.
// Reset, or a length write outside S_READ, clears sum, position and wrap flag.
// A stalled result sits in the output register while the next sample
// is taken; the divider holds its quotient until that register frees up.
// ----------------------------------------------------------------------------
module moving_average_window #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                window_length_wr,
  input  logic [mav_pkg::CFG_W-1:0]           window_length,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [mav_pkg::SAMPLE_W-1:0] sample,
  output logic                                average_valid,
  input  logic                                average_stall,
  output logic signed [mav_pkg::SAMPLE_W-1:0] average
);
  import mav_pkg::*;

  localparam int POS_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + POS_W;
  localparam int RESET_LEN = (MAX_WINDOW < RESET_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                     state;
  logic [POS_W-1:0]           pos;
  logic [LEN_W-1:0]           len;
  logic                       wrapped;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sample_q;

  logic [LEN_W-1:0]           len_cfg;
  logic [LEN_W-1:0]           pos_inc;
  logic                       pos_wrap;
  logic signed [SUM_W-1:0]    old_ext;
  logic signed [SUM_W-1:0]    sum_next;

  ring_cmd_t                  ring_cmd;
  logic signed [SAMPLE_W-1:0] ring_rd;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;
  logic                       out_free;

  // Saturate the written length into the legal range.
  always_comb begin
    if (int'(window_length) < MIN_WINDOW) begin
      len_cfg = LEN_W'(MIN_WINDOW);
    end else if (int'(window_length) > MAX_WINDOW) begin
      len_cfg = LEN_W'(MAX_WINDOW);
    end else begin
      len_cfg = LEN_W'(window_length);
    end
  end

  always_comb begin
    pos_inc  = LEN_W'(pos) + LEN_W'(1);
    pos_wrap = pos_inc >= len;
    // Drop the old entry only once the ring has wrapped since the clear.
    old_ext  = wrapped ? SUM_W'(ring_rd) : '0;
    sum_next = sum - old_ext + SUM_W'(sample_q);
    ring_cmd.rd  = (state == S_IDLE) && sample_valid;
    ring_cmd.wr  = (state == S_READ);
    div_start    = (state == S_START);
    sample_stall = (state != S_IDLE);
    out_free     = !average_valid || !average_stall;
  end

  mav_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (POS_W)
  ) u_ring (
    .clk     (clk),
    .cmd     (ring_cmd),
    .addr    (pos),
    .wr_data (sample_q),
    .rd_data (ring_rd)
  );

  mav_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      len           <= LEN_W'(RESET_LEN);
      wrapped       <= 1'b0;
      sum           <= '0;
      average_valid <= 1'b0;
    end else begin
      if (average_valid && !average_stall) begin
        average_valid <= 1'b0;
      end
      if (window_length_wr) begin
        len     <= len_cfg;
        pos     <= '0;
        wrapped <= 1'b0;
        sum     <= '0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            sample_q <= sample;
            state    <= S_READ;
          end
        end
        S_READ: begin
          sum <= sum_next;
          if (pos_wrap) begin
            pos     <= '0;
            wrapped <= 1'b1;
          end else begin
            pos <= POS_W'(pos_inc);
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (out_free) begin
              average       <= div_q;
              average_valid <= 1'b1;
              state         <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            average       <= div_q;
            average_valid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/mav_checker.sv]
// ----------------------------------------------------------------------------
// mav_checker
// Port-level checks for the moving average window block.
// ----------------------------------------------------------------------------
module mav_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic                                average_valid,
  input logic                                average_stall,
  input logic signed [mav_pkg::SAMPLE_W-1:0] average
);
  import mav_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    average_valid && average_stall |=> average_valid && $stable(average))
    else $error("stalled average beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous beat still in work");

  a_busy_two: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> ##1 sample_stall)
    else $error("block idle too soon after accepting a sample");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !average_valid)
    else $error("average valid right after reset");

endmodule

bind moving_average_window mav_checker u_mav_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks moving_average_window against a cycle-free boxcar predictor: every
// accepted sample beat updates a private copy of the ring and the running
// sum, and the predicted average is queued. Each accepted average beat is
// compared with the oldest queued value. Covers the reset length, length
// saturation on both ends, rewrites of the same length, and long random runs
// with random window lengths while the sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mav_pkg::*;

  localparam int MAX_WINDOW    = 64;
  localparam int SUM_W         = 38;
  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 1730;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh80000000;

  typedef enum int {MIX_RANDOM, MIX_HIGH, MIX_LOW} sample_mix_t;

  logic                       clk;
  logic                       rst              = 1'b1;
  logic                       window_length_wr = 1'b0;
  logic [CFG_W-1:0]           window_length    = CFG_W'(RESET_WINDOW);
  logic                       sample_valid     = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample           = '0;
  logic                       average_valid;
  logic                       average_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] average;

  // Boxcar predictor state
  logic signed [SAMPLE_W-1:0] ring_copy [MAX_WINDOW];
  logic [5:0]                 ring_pos;
  logic signed [SUM_W-1:0]    ring_sum;
  logic [CFG_W-1:0]           ring_len;

  logic signed [SAMPLE_W-1:0] pending_averages [$];
  int                         fail_count  = 0;
  int                         burst_left  = 0;
  int                         stall_mode  = 0;
  int                         stall_left  = 0;
  int                         idle_cycles = 0;

  moving_average_window #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .window_length_wr (window_length_wr),
    .window_length    (window_length),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .average_valid    (average_valid),
    .average_stall    (average_stall),
    .average          (average)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CFG_W-1:0] clamp_length(input logic [CFG_W-1:0] raw);
    if (raw < CFG_W'(MIN_WINDOW)) return CFG_W'(MIN_WINDOW);
    if (raw > CFG_W'(MAX_WINDOW)) return CFG_W'(MAX_WINDOW);
    return raw;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < MAX_WINDOW; i++) ring_copy[i] = '0;
    ring_pos = '0;
    ring_sum = '0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_average(
    input logic signed [SAMPLE_W-1:0] value
  );
    logic signed [SUM_W-1:0] len_s;
    logic signed [SUM_W-1:0] quot;
    len_s = SUM_W'(ring_len);
    if (ring_pos >= ring_len) ring_pos = '0;
    ring_sum = ring_sum - ring_copy[ring_pos] + value;
    ring_copy[ring_pos] = value;
    ring_pos = ring_pos + 6'd1;
    if (ring_pos >= ring_len) ring_pos = '0;
    // signed division truncates toward zero
    quot = ring_sum / len_s;
    return quot[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_mix_t mix);
    logic signed [SAMPLE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2: v = int'($urandom_range(0, 16)) - 8;
      default: ;
    endcase
    if (mix == MIX_HIGH && $urandom_range(0, 3) != 0) v = SAMPLE_MAX;
    if (mix == MIX_LOW && $urandom_range(0, 3) != 0) v = SAMPLE_MIN;
    return v;
  endfunction

  task automatic report_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Send one sample beat; open a new burst after a random gap when due.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    do @(posedge clk); while (sample_stall);
    pending_averages.push_back(predict_average(value));
    burst_left--;
  endtask

  // Hold the sender until every predicted average has come back.
  task automatic drain_averages();
    sample_valid <= 1'b0;
    burst_left = 0;
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  task automatic set_window_length(input logic [CFG_W-1:0] raw);
    drain_averages();
    repeat (SETTLE_CYCLES) @(posedge clk);
    window_length_wr <= 1'b1;
    window_length    <= raw;
    @(posedge clk);
    window_length_wr <= 1'b0;
    ring_len = clamp_length(raw);
    clear_ring();
  endtask

  task automatic test_default_window();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    send_sample(-32'sd7);
    send_sample(32'sd7);
    send_sample(32'sd0);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic test_length_limits();
    set_window_length(7'd0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    set_window_length(7'd1);
    send_sample(-32'sd1);
    send_sample(-32'sd2);
    set_window_length(7'd127);
    send_sample(SAMPLE_MIN);
    send_sample(-32'sd1);
    set_window_length(7'd65);
    send_sample(32'sd5);
    set_window_length(7'd64);
    send_sample(SAMPLE_MAX);
    set_window_length(7'd2);
    send_sample(32'sd3);
    // same value again still clears
    set_window_length(7'd2);
    send_sample(32'sd3);
  endtask

  task automatic test_random_windows();
    int               sent;
    int               count;
    logic [CFG_W-1:0] raw;
    sample_mix_t      mix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 6))
            0: raw = 7'd0;
            1: raw = 7'd1;
            2: raw = 7'd2;
            3: raw = 7'd63;
            4: raw = 7'd64;
            5: raw = 7'd65;
            default: raw = 7'd127;
          endcase
        end
        1, 2: raw = CFG_W'($urandom_range(2, 12));
        default: raw = CFG_W'($urandom_range(0, 127));
      endcase
      set_window_length(raw);
      mix = ($urandom_range(0, 3) != 0) ? MIX_RANDOM
                                        : sample_mix_t'($urandom_range(1, 2));
      count = $urandom_range(1, 3 * int'(clamp_length(raw)) + 8);
      for (int i = 0; i < count; i++) begin
        send_sample(pick_sample(mix));
        sent++;
        if ($urandom_range(0, 199) == 0) drain_averages();
      end
    end
  endtask

  // Check average beats and drive the receiver stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      average_stall <= 1'b0;
    end else begin
      if (average_valid && !average_stall) begin
        if (pending_averages.size() == 0) begin
          report_failure($sformatf("unexpected average %0d", average));
        end else if (average !== pending_averages[0]) begin
          report_failure($sformatf("average mismatch: expected %0d, actual %0d",
                                   pending_averages[0], average));
          void'(pending_averages.pop_front());
        end else begin
          void'(pending_averages.pop_front());
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       average_stall <= 1'b0;
        1:       average_stall <= ($urandom_range(0, 3) == 0);
        default: average_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  initial begin
    @(negedge rst);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (average_valid && !average_stall) ||
          window_length_wr)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    ring_len = CFG_W'(RESET_WINDOW);
    clear_ring();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_length_limits();
    test_random_windows();
    drain_averages();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_averages.size() != 0)
      report_failure($sformatf("%0d averages never arrived", pending_averages.size()));
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
